FILE: design/ufph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find package
// Shared widths, packed command/status types, FSM states and the saturating
// access-count adder for the path-halving union-find core.
// ----------------------------------------------------------------------------
package ufph_pkg;

    // Node count of the forest. The design assumes a power of two, so that
    // reducing a node number into range is a plain truncation.
    localparam int NODES   = 1024;
    localparam int NODE_W  = $clog2(NODES);
    localparam int SIZE_W  = $clog2(NODES) + 1;
    localparam int FIELD_W = 10;
    localparam int CNT_W   = 8;
    localparam int INC_W   = 4;

    localparam int S_DATA_W = ((2 * FIELD_W) + 7) / 8 * 8;
    localparam int M_DATA_W = ((1 + FIELD_W + CNT_W) + 7) / 8 * 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [INC_W-1:0] INC_FIND  = 4'd1;
    localparam logic [INC_W-1:0] HOP_COST  = 4'd5;
    localparam logic [INC_W-1:0] INC_LINK  = 4'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_HALVE,
        ST_SIZE_I,
        ST_SIZE_J,
        ST_LINK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd_from_data;
        logic hop;
        logic halve;
        logic root_first;
        logic root_second;
        logic sz_rd_j;
        logic sz_cap_i;
        logic link;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_root;
        logic roots_eq;
    } t_stat;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [FIELD_W-1:0] root;
        logic               joined;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [INC_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W + 1)'(b);
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] reduce_node(input logic [FIELD_W-1:0] n);
        return NODE_W'(n);
    endfunction

endpackage

FILE: design/ufph_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find controller
// Sequences the clearing sweep, the two root walks with path halving, the
// weighted link and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module ufph_ctrl
    import ufph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_READ;
                    n_second = 1'b0;
                end
            end
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: begin
                if (!i_stat.is_root) begin
                    n_state = ST_HALVE;
                end else if (!r_second) begin
                    n_state  = ST_READ;
                    n_second = 1'b1;
                end else if (i_stat.roots_eq) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SIZE_I;
                end
            end
            ST_HALVE:  n_state = ST_CHECK;
            ST_SIZE_I: n_state = ST_SIZE_J;
            ST_SIZE_J: n_state = ST_LINK;
            ST_LINK:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_CHECK: begin
                if (!i_stat.is_root) begin
                    o_cmd.hop          = 1'b1;
                    o_cmd.rd_from_data = 1'b1;
                end else if (!r_second) begin
                    o_cmd.root_first = 1'b1;
                end else begin
                    o_cmd.root_second = 1'b1;
                end
            end
            ST_HALVE: begin
                o_cmd.halve        = 1'b1;
                o_cmd.rd_from_data = 1'b1;
            end
            ST_SIZE_J: begin
                o_cmd.sz_rd_j  = 1'b1;
                o_cmd.sz_cap_i = 1'b1;
            end
            ST_LINK:  o_cmd.link     = 1'b1;
            ST_DONE:  o_cmd.load_out = i_out_free;
            default:  o_cmd          = '0;
        endcase
    end

    // A result is handed over only at the end of an item's work.
    a_load_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (r_state == ST_DONE))
        else $error("result load outside the done state");

endmodule

FILE: design/ufph_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find datapath
// Parent and tree-size memories, the walk pointer, the two roots, the
// saturating access counter and the clearing-sweep index.
// ----------------------------------------------------------------------------
module ufph_dp
    import ufph_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [FIELD_W-1:0] i_p_node,
    input  logic [FIELD_W-1:0] i_q_node,
    output t_stat              o_stat,
    output t_result            o_result
);

    logic [NODE_W-1:0] mem_parent [NODES];
    logic [SIZE_W-1:0] mem_size   [NODES];

    logic [NODE_W-1:0] r_clr_idx;
    logic [NODE_W-1:0] r_x, r_q, r_ri, r_rj, r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_joined;
    logic [NODE_W-1:0] r_par_rd;
    logic [SIZE_W-1:0] r_sz_rd, r_sz_i;

    logic [NODE_W-1:0] par_rd_addr, par_wr_addr, par_wr_data;
    logic              par_wr_en;
    logic [NODE_W-1:0] sz_rd_addr, sz_wr_addr;
    logic [SIZE_W-1:0] sz_wr_data;
    logic              sz_wr_en;
    logic              i_smaller;
    logic [SIZE_W-1:0] sz_sum;

    assign par_rd_addr = i_cmd.rd_from_data ? r_par_rd : r_x;
    assign sz_rd_addr  = i_cmd.sz_rd_j ? r_rj : r_ri;
    assign i_smaller   = r_sz_i < r_sz_rd;
    assign sz_sum      = r_sz_i + r_sz_rd;

    // Write port selection: sweep, halving re-point, or link.
    always_comb begin
        par_wr_en   = 1'b0;
        par_wr_addr = r_x;
        par_wr_data = r_par_rd;
        sz_wr_en    = 1'b0;
        sz_wr_addr  = r_ri;
        sz_wr_data  = sz_sum;
        if (i_cmd.clr_step) begin
            par_wr_en   = 1'b1;
            par_wr_addr = r_clr_idx;
            par_wr_data = r_clr_idx;
            sz_wr_en    = 1'b1;
            sz_wr_addr  = r_clr_idx;
            sz_wr_data  = SIZE_W'(1);
        end else if (i_cmd.halve) begin
            par_wr_en = 1'b1;
        end else if (i_cmd.link) begin
            par_wr_en   = 1'b1;
            sz_wr_en    = 1'b1;
            par_wr_addr = i_smaller ? r_ri : r_rj;
            par_wr_data = i_smaller ? r_rj : r_ri;
            sz_wr_addr  = i_smaller ? r_rj : r_ri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_wr_en) mem_parent[par_wr_addr] <= par_wr_data;
        r_par_rd <= mem_parent[par_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sz_wr_en) mem_size[sz_wr_addr] <= sz_wr_data;
        r_sz_rd <= mem_size[sz_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x   <= reduce_node(i_p_node);
            r_q   <= reduce_node(i_q_node);
            r_cnt <= sat_add('0, INC_FIND);
        end
        if (i_cmd.hop) begin
            r_cnt <= sat_add(r_cnt, HOP_COST);
        end
        if (i_cmd.halve) begin
            r_x <= r_par_rd;
        end
        if (i_cmd.root_first) begin
            r_ri  <= r_x;
            r_x   <= r_q;
            r_cnt <= sat_add(r_cnt, INC_FIND);
        end
        if (i_cmd.root_second) begin
            r_rj     <= r_x;
            r_joined <= o_stat.roots_eq;
            r_root   <= r_ri;
        end
        if (i_cmd.sz_cap_i) begin
            r_sz_i <= r_sz_rd;
        end
        if (i_cmd.link) begin
            r_cnt  <= sat_add(r_cnt, INC_LINK);
            r_root <= i_smaller ? r_rj : r_ri;
        end
    end

    assign o_stat.clr_last = (r_clr_idx == NODE_W'(NODES - 1));
    assign o_stat.is_root  = (r_par_rd == r_x);
    assign o_stat.roots_eq = (r_ri == r_x);

    assign o_result.joined = r_joined;
    assign o_result.root   = FIELD_W'(r_root);
    assign o_result.cnt    = r_cnt;

    // A halving step never re-points a node at itself; that would mean a cycle.
    a_halve_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.halve |-> (r_par_rd != r_x))
        else $error("path halving hit a parent cycle");

    // Linking only ever joins two distinct roots.
    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.link |-> (r_ri != r_rj))
        else $error("link of a root to itself");

endmodule

FILE: design/union_find_path_halving_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find core with path halving
// Weighted quick-union engine over a 1024-node forest held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the slave channel carries a pair of node numbers to join.
// The block walks to the root of each node, re-pointing every visited node
// to its grandparent, then links the smaller tree under the larger one (the
// second root goes under the first on a tie). One result beat follows each
// input beat on the master channel: already-joined flag, surviving root and
// the saturating parent-access count.
// Timing: a pair that needs a link also passes the two size-read states and
// the link state before its result is ready; H counts the halving hops of
// both walks, and the next pair is taken once the engine is back in idle.
// A hop makes two dependent reads of the single parent-memory read port.
// Trees stay at most log2(NODES) deep and a hop climbs two levels, so H <= 10.
// Only one pair is in flight at a time; a new pair can be accepted while the
// previous result still sits in the output register.
// Reset: after reset the block sweeps all 1024 entries of both memories, one
// entry per cycle, and holds the slave tready low during that sweep.
// Stall: if the master side stalls, a finished result waits in the output
// register and the engine holds in its done state until it is taken.
// ----------------------------------------------------------------------------
module union_find_path_halving_core
    import ufph_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // p_node, q_node, zero pad
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata    // already_joined, final_root,
                                             // access_count, zero pad
);

    t_cmd    cmd;
    t_stat   stat;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !r_out_valid || i_m_tready;

    ufph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    ufph_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_p_node (i_s_tdata[FIELD_W-1:0]),
        .i_q_node (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .o_stat   (stat),
        .o_result (result)
    );

    // Output register: loads a new result or drops the beat just taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) r_out <= result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'({r_out.cnt, r_out.root, r_out.joined});

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && r_out_valid) |-> i_m_tready)
        else $error("result register overwritten while stalled");

endmodule

FILE: test/union_find_path_halving_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find core testbench
// Drives pairs of node numbers into the path-halving union-find core and
// checks every result beat against a behavioral disjoint-set forest that is
// kept in step with the accepted input beats. A short table of directed pairs
// comes first. Random pairs follow: binomial merges that grow deep trees,
// pairs from a local window, and pairs over the whole node range. Both sides
// stall at random.
// ----------------------------------------------------------------------------
module union_find_path_halving_core_tb;
    import ufph_pkg::*;

    localparam int          HOP_ACCESSES   = 5;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_PAIRS   = 1080;
    localparam int          DIR_ROWS       = 18;
    localparam int          BLOCK_NODES    = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] q;
    } t_pair;

    // Directed row: when typed is set, the expected fields are checked as
    // written here instead of the forest prediction.
    typedef struct packed {
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] q;
        logic               typed;
        logic               joined;
        logic [FIELD_W-1:0] root;
        logic [CNT_W-1:0]   cnt;
    } t_row;

    localparam t_row PAIR_TABLE [DIR_ROWS] = '{
        '{10'd0,    10'd1023, 1'b1, 1'b0, 10'd0,    8'd3},   // fresh pair, tie
        '{10'd0,    10'd1023, 1'b1, 1'b1, 10'd0,    8'd7},   // one halving hop
        '{10'd1023, 10'd0,    1'b1, 1'b1, 10'd0,    8'd7},
        '{10'd512,  10'd512,  1'b1, 1'b1, 10'd512,  8'd2},   // same node twice
        '{10'd341,  10'd682,  1'b1, 1'b0, 10'd341,  8'd3},   // alternating bits
        '{10'd682,  10'd341,  1'b1, 1'b1, 10'd341,  8'd7},
        '{10'd1022, 10'd1021, 1'b1, 1'b0, 10'd1022, 8'd3},
        '{10'd1022, 10'd0,    1'b1, 1'b0, 10'd1022, 8'd3},   // tie of size two
        '{10'd1023, 10'd1021, 1'b0, 1'b0, 10'd0,    8'd0},
        '{10'd2,    10'd3,    1'b1, 1'b0, 10'd2,    8'd3},
        '{10'd4,    10'd5,    1'b1, 1'b0, 10'd4,    8'd3},
        '{10'd2,    10'd4,    1'b1, 1'b0, 10'd2,    8'd3},
        '{10'd5,    10'd3,    1'b0, 1'b0, 10'd0,    8'd0},
        '{10'd6,    10'd2,    1'b1, 1'b0, 10'd2,    8'd3},   // smaller first
        '{10'd2,    10'd7,    1'b1, 1'b0, 10'd2,    8'd3},   // larger first
        '{10'd1,    10'd1,    1'b1, 1'b1, 10'd1,    8'd2},
        '{10'd1023, 10'd1023, 1'b0, 1'b0, 10'd0,    8'd0},
        '{10'd1021, 10'd682,  1'b0, 1'b0, 10'd0,    8'd0}    // unequal sizes
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;   // p_node, q_node, zero pad
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;         // already_joined, final_root,
                                            // access_count, zero pad

    // Behavioral forest and the results it predicts, oldest first.
    logic [NODE_W-1:0]   forest_up   [NODES];
    logic [SIZE_W-1:0]   tree_weight [NODES];
    t_result             pending_results [$];

    int unsigned         mismatches = 0;
    int unsigned         idle_cycles = 0;
    int unsigned         rx_hold = 0;
    int unsigned         rx_draw;
    bit                  steady = 1'b0;

    union_find_path_halving_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c,
                                                  input int unsigned v);
        int unsigned s;
        s = c + v;
        return (s > COUNT_MAX) ? COUNT_MAX : CNT_W'(s);
    endfunction

    // Walks to the root, pointing each visited node at its grandparent.
    task automatic walk_to_root(inout logic [NODE_W-1:0] x,
                                inout logic [CNT_W-1:0] c);
        int unsigned hops;
        hops = 0;
        while (x != forest_up[x] && hops < NODES) begin
            c = count_up(c, HOP_ACCESSES);
            forest_up[x] = forest_up[forest_up[x]];
            x = forest_up[x];
            hops++;
        end
    endtask

    task automatic join_pair(input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] q,
                             output t_result res);
        logic [NODE_W-1:0] ri;
        logic [NODE_W-1:0] rj;
        logic [CNT_W-1:0]  c;
        ri = NODE_W'(p);
        rj = NODE_W'(q);
        c  = count_up('0, 1);
        walk_to_root(ri, c);
        c  = count_up(c, 1);
        walk_to_root(rj, c);
        if (ri == rj) begin
            res.joined = 1'b1;
            res.root   = FIELD_W'(ri);
        end else begin
            res.joined = 1'b0;
            c = count_up(c, 1);
            if (tree_weight[ri] < tree_weight[rj]) begin
                forest_up[ri]   = rj;
                tree_weight[rj] = tree_weight[rj] + tree_weight[ri];
                res.root        = FIELD_W'(rj);
            end else begin
                forest_up[rj]   = ri;
                tree_weight[ri] = tree_weight[ri] + tree_weight[rj];
                res.root        = FIELD_W'(ri);
            end
        end
        res.cnt = c;
    endtask

    // Offers one pair after a gap, waits for the beat, then records what the
    // forest predicts (or the typed-in result for a directed row).
    task automatic send_pair(input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] q,
                             input int unsigned gap, input bit typed, input t_result want);
        t_result got;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'({q, p});
        do @(posedge i_clk); while (!o_s_tready);
        join_pair(p, q, got);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    // Result side: random tready stalls and the field-by-field check.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_hold    <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no pair outstanding: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                if (o_m_tdata[0] !== pending_results[0].joined) begin
                    $error("already_joined: expected %0d, got %0d",
                           pending_results[0].joined, o_m_tdata[0]);
                    mismatches++;
                end
                if (o_m_tdata[FIELD_W:1] !== pending_results[0].root) begin
                    $error("final_root: expected %0d, got %0d",
                           pending_results[0].root, o_m_tdata[FIELD_W:1]);
                    mismatches++;
                end
                if (o_m_tdata[FIELD_W+CNT_W:FIELD_W+1] !== pending_results[0].cnt) begin
                    $error("access_count: expected %0d, got %0d",
                           pending_results[0].cnt, o_m_tdata[FIELD_W+CNT_W:FIELD_W+1]);
                    mismatches++;
                end
                void'(pending_results.pop_front());
            end
            rx_draw = draw_gap();
            if (rx_draw != 0) begin
                i_m_tready <= 1'b0;
                rx_hold    <= rx_draw - 1;
            end
        end else if (!i_m_tready) begin
            if (rx_hold == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_pair       block_pairs [$];
        t_pair       pr;
        t_result     want;
        int unsigned next_block;
        int unsigned base;
        int unsigned sel;
        int unsigned stride;
        int unsigned i;

        next_block = 1;
        for (i = 0; i < NODES; i++) begin
            forest_up[i]   = NODE_W'(i);
            tree_weight[i] = SIZE_W'(1);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PAIR_TABLE[r]) begin
            want.joined = PAIR_TABLE[r].joined;
            want.root   = PAIR_TABLE[r].root;
            want.cnt    = PAIR_TABLE[r].cnt;
            send_pair(PAIR_TABLE[r].p, PAIR_TABLE[r].q, draw_gap(),
                      PAIR_TABLE[r].typed, want);
        end
        drain_results();

        want = '0;
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // Binomial merge of one block of nodes: equal-size roots are
            // joined level by level, which builds the deepest weighted trees.
            if (block_pairs.size() == 0 && next_block < NODES / BLOCK_NODES - 1 &&
                $urandom_range(0, 3) == 0) begin
                base = next_block * BLOCK_NODES;
                for (stride = 1; stride < BLOCK_NODES; stride = stride * 2) begin
                    for (i = 0; i < BLOCK_NODES; i = i + 2 * stride) begin
                        block_pairs.push_back('{FIELD_W'(base + i),
                                                FIELD_W'(base + i + stride)});
                    end
                end
                next_block++;
            end
            sel = $urandom_range(0, 9);
            if (block_pairs.size() != 0 && sel < 6) begin
                pr = block_pairs.pop_front();
            end else if (sel < 8) begin
                pr.p = FIELD_W'($urandom_range(0, NODES - 1));
                pr.q = pr.p + FIELD_W'($urandom_range(0, BLOCK_NODES - 1));
            end else begin
                pr.p = FIELD_W'($urandom_range(0, NODES - 1));
                pr.q = FIELD_W'($urandom_range(0, NODES - 1));
            end
            if ($urandom_range(0, 39) == 0) begin
                steady = !steady;
            end
            if (n % 250 == 125) begin
                drain_results();
            end
            send_pair(pr.p, pr.q, draw_gap(), 1'b0, want);
        end

        drain_results();
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
